/* src/plb_pkg.sv */
// Package for the positional list buffer: widths, request and status codes,
// cell command types. No dependencies.
`default_nettype none

package plb_pkg;

	// Default capacity of the list, in cells
	localparam int unsigned DEPTH_DEF = 32;

	// Field widths fixed by the beat format
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned STATUS_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_DELETE   = 2'd1,
		REQ_TRAVERSE = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_BOUNDS  = 3'd2,
		STAT_FULL    = 3'd3,
		STAT_EMPTY   = 3'd4
	} status_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_ROTATE = 2'd3
	} cell_cmd_t;

	// idx: target cell for insert/delete, last occupied cell for rotate
	typedef struct packed {
		cell_cmd_t          cmd;
		logic [POS_W-1:0]   idx;
	} cell_ctl_t;

	typedef enum logic {
		PS_IDLE = 1'b0,
		PS_TRAV = 1'b1
	} plb_state_t;

endpackage

`default_nettype wire

/* src/plb_if.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on plb_pkg for field widths.
`default_nettype none

interface plb_req_if;
	import plb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output req_type, output value, output position,
		input ready);
	modport sink (input valid, input req_type, input value, input position,
		output ready);
endinterface

interface plb_rsp_if;
	import plb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	modport source (output valid, output status, output element, output last,
		input ready);
	modport sink (input valid, input status, input element, input last,
		output ready);
endinterface

`default_nettype wire

/* src/positional_list_buffer.sv */
// Top level of the positional list buffer: request decode, control FSM,
// output register and the chain of plb_cell. Depends on plb_pkg, plb_if.
//
// The list lives in a chain of DEPTH cells, one entry per cell. On insert
// and delete every cell shifts toward or away from the target position at
// once, and one status beat follows. A traverse of N entries emits N beats,
// one per cycle while each beat is taken, by rotating the chain through
// cell 0 and wrapping the head into the last occupied cell, so the list ends
// up in its original order; an empty traverse gives one beat. No new request
// is taken until the last beat of a traverse is in the output register, and
// a waiting response beat that is not taken holds off the next request. A
// request is accepted in the same cycle as the waiting response beat is
// taken, so inserts and deletes run at one per cycle while the response
// side keeps up.
`default_nettype none

module positional_list_buffer #(
	parameter int unsigned DEPTH = plb_pkg::DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	plb_req_if.sink   req_ch,
	plb_rsp_if.source rsp_ch
);
	import plb_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	plb_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  trav_cnt_q;

	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [DATA_W-1:0]   rsp_element_q;
	logic                rsp_last_q;

	logic [DATA_W-1:0] cell_data [DEPTH];
	cell_ctl_t         ctl;

	logic              rsp_free;
	logic              req_accept;
	req_t              req_kind;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;
	logic [POS_W-1:0]  pos_idx;
	logic [POS_W-1:0]  last_idx;
	logic              trav_last;
	status_t           ins_status;
	status_t           del_status;

	logic              load;
	status_t           ld_status;
	logic [DATA_W-1:0] ld_element;
	logic              ld_last;
	logic              trav_start;
	logic              trav_step;
	logic              cnt_inc;
	logic              cnt_dec;

	assign rsp_free   = !rsp_valid_q || rsp_ch.ready;
	assign req_accept = req_ch.valid && req_ch.ready;
	assign req_kind   = req_t'(req_ch.req_type);
	assign pos_x      = CMP_W'(req_ch.position);
	assign cnt_x      = CMP_W'(count_q);
	assign pos_idx    = req_ch.position - POS_W'(1);
	assign last_idx   = POS_W'(count_q - CNT_W'(1));
	assign trav_last  = (trav_cnt_q == last_idx);

	// status checks; position checks come before the full check
	always_comb begin
		if (req_ch.position == '0) begin
			ins_status = STAT_INVALID;
		end else if (pos_x > cnt_x + CMP_W'(1)) begin
			ins_status = STAT_BOUNDS;
		end else if (count_q == CNT_W'(DEPTH)) begin
			ins_status = STAT_FULL;
		end else begin
			ins_status = STAT_OK;
		end
	end

	always_comb begin
		if (req_ch.position == '0 || count_q == '0) begin
			del_status = STAT_INVALID;
		end else if (pos_x > cnt_x) begin
			del_status = STAT_BOUNDS;
		end else begin
			del_status = STAT_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PS_IDLE: begin
				if (req_accept && req_kind == REQ_TRAVERSE && count_q != '0) begin
					state_d = PS_TRAV;
				end
			end
			PS_TRAV: begin
				if (rsp_free && trav_last) begin
					state_d = PS_IDLE;
				end
			end
			default: state_d = PS_IDLE;
		endcase
	end

	// FSM outputs: request ready, cell command, output register load
	always_comb begin
		req_ch.ready = 1'b0;
		ctl.cmd      = CMD_HOLD;
		ctl.idx      = '0;
		load         = 1'b0;
		ld_status    = STAT_OK;
		ld_element   = '0;
		ld_last      = 1'b1;
		trav_start   = 1'b0;
		trav_step    = 1'b0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		unique case (state_q)
			PS_IDLE: begin
				req_ch.ready = rsp_free;
				if (req_accept) begin
					unique case (req_kind)
						REQ_INSERT: begin
							load      = 1'b1;
							ld_status = ins_status;
							if (ins_status == STAT_OK) begin
								ctl.cmd = CMD_INSERT;
								ctl.idx = pos_idx;
								cnt_inc = 1'b1;
							end
						end
						REQ_DELETE: begin
							load      = 1'b1;
							ld_status = del_status;
							if (del_status == STAT_OK) begin
								ctl.cmd = CMD_DELETE;
								ctl.idx = pos_idx;
								cnt_dec = 1'b1;
							end
						end
						REQ_TRAVERSE: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = STAT_EMPTY;
							end else begin
								trav_start = 1'b1;
							end
						end
						default: begin
							// unused code: no beat, no change
						end
					endcase
				end
			end
			PS_TRAV: begin
				if (rsp_free) begin
					load       = 1'b1;
					ld_status  = STAT_OK;
					ld_element = cell_data[0];
					ld_last    = trav_last;
					trav_step  = 1'b1;
					ctl.cmd    = CMD_ROTATE;
					ctl.idx    = last_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PS_IDLE;
			count_q     <= '0;
			trav_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (trav_start) begin
				trav_cnt_q <= '0;
			end else if (trav_step) begin
				trav_cnt_q <= trav_cnt_q + POS_W'(1);
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status_q  <= ld_status;
			rsp_element_q <= ld_element;
			rsp_last_q    <= ld_last;
		end
	end

	assign rsp_ch.valid   = rsp_valid_q;
	assign rsp_ch.status  = rsp_status_q;
	assign rsp_ch.element = rsp_element_q;
	assign rsp_ch.last    = rsp_last_q;

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_data = '0;
		end else begin : g_right
			assign right_data = cell_data[i+1];
		end

		plb_cell #(
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (req_ch.value),
			.left  (left_data),
			.right (right_data),
			.head  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

endmodule

`default_nettype wire

/* src/plb_cell.sv */
// One storage cell of the list chain: holds one entry and takes its
// neighbor's value on insert, delete and rotate. Depends on plb_pkg.
`default_nettype none

module plb_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic                          clk,
	input  wire plb_pkg::cell_ctl_t            ctl,
	input  wire logic [plb_pkg::DATA_W-1:0]    value,
	input  wire logic [plb_pkg::DATA_W-1:0]    left,
	input  wire logic [plb_pkg::DATA_W-1:0]    right,
	input  wire logic [plb_pkg::DATA_W-1:0]    head,
	output logic [plb_pkg::DATA_W-1:0]         data
);
	import plb_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	// next entry value
	always_comb begin
		data_d = data_q;
		unique case (ctl.cmd)
			CMD_HOLD: data_d = data_q;
			CMD_INSERT: begin
				if (MY_IDX == ctl.idx) begin
					data_d = value;
				end else if (MY_IDX > ctl.idx) begin
					data_d = left;
				end
			end
			CMD_DELETE: begin
				if (MY_IDX >= ctl.idx) begin
					data_d = right;
				end
			end
			CMD_ROTATE: begin
				// head wraps into the last occupied cell
				if (MY_IDX == ctl.idx) begin
					data_d = head;
				end else if (MY_IDX < ctl.idx) begin
					data_d = right;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

/* src/plb_checker.sv */
// Port-level checks for positional_list_buffer, attached by bind.
// Depends on plb_pkg for status codes.
`default_nettype none

module plb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [plb_pkg::STATUS_W-1:0]  rsp_status,
	input wire logic [plb_pkg::DATA_W-1:0]    rsp_element,
	input wire logic                          rsp_last
);
	import plb_pkg::*;

	// a response beat that is not taken stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped before it was taken");

	// while a traverse run is still open no request is taken
	a_trav_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("request taken in the middle of a traverse run");

	// status-only beats end their run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_last)
		else $error("error status on a beat that is not last");

	// status-only beats carry a zero element
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_element == '0)
		else $error("non-zero element on a status beat");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req_ch.ready),
	.rsp_valid   (rsp_ch.valid),
	.rsp_ready   (rsp_ch.ready),
	.rsp_status  (rsp_ch.status),
	.rsp_element (rsp_ch.element),
	.rsp_last    (rsp_ch.last)
);

`default_nettype wire
